### rtl/tks_pkg.sv
// tks_pkg: shared types, constants and float ordering helpers for the top-k score keeper.
// No dependencies.
`default_nettype none
package tks_pkg;

  localparam int unsigned MAX_KEEP_DEF = 128;
  localparam int unsigned ID_BITS_DEF  = 24;
  localparam logic [31:0] EMPTY_SCORE  = 32'hFF7F_FFFF;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic        ins;
    logic        clr;
    logic [31:0] score;
  } cell_ctl_t;

  function automatic logic is_nan(input logic [31:0] x);
    return x[30:0] > 31'h7F80_0000;
  endfunction

  // Monotone unsigned key; both zeros map to the same key.
  function automatic logic [31:0] order_key(input logic [31:0] x);
    logic [31:0] v;
    v = (x[30:0] == 31'd0) ? 32'd0 : x;
    return v[31] ? ~v : (v | 32'h8000_0000);
  endfunction

  function automatic logic float_gt(input logic [31:0] a, input logic [31:0] b);
    return !is_nan(a) && !is_nan(b) && (order_key(a) > order_key(b));
  endfunction

endpackage
`default_nettype wire

### rtl/tks_cell.sv
// tks_cell: one rank slot of the insertion chain; holds id, score and full flag.
// Depends on tks_pkg.
`default_nettype none
module tks_cell #(
  parameter int unsigned ID_BITS = tks_pkg::ID_BITS_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  tks_pkg::cell_ctl_t      ctl,
  input  wire [ID_BITS-1:0]       new_id,
  input  wire                     in_use,
  input  wire                     prev_found,
  input  wire [ID_BITS-1:0]       left_id,
  input  wire [31:0]              left_score,
  input  wire                     left_full,
  output logic                    found,
  output logic                    first,
  output logic [ID_BITS-1:0]      id,
  output logic [31:0]             score,
  output logic                    full
);
  import tks_pkg::*;

  logic hit;

  // List stays sorted best first, so a hit in the left neighbor implies one here when this slot is in use.
  assign hit   = in_use && float_gt(ctl.score, score);
  assign found = hit;
  assign first = hit && !prev_found;

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      id    <= '0;
      score <= EMPTY_SCORE;
      full  <= 1'b0;
    end else if (ctl.ins && in_use) begin
      if (first) begin
        id    <= new_id;
        score <= ctl.score;
        full  <= 1'b1;
      end else if (prev_found) begin
        id    <= left_id;
        score <= left_score;
        full  <= left_full;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/top_k_score_keeper.sv
// top_k_score_keeper: chain of tks_cell slots with request decode and result register.
// Depends on tks_pkg and tks_cell.
//
// Use: requests enter on in_valid/in_stall with func, cand_id, cand_score and
// slot_index; each request yields one result on out_valid/out_stall.
// Insert compares the score against every slot at once, the chain of cells
// shifts the lower slots down by one and the new pair lands at the first
// slot it beats; the result reports inserted and placed_rank. Read returns
// one slot; clear empties every slot.
// The result is registered and shows on the cycle after the request is
// taken. One request per cycle is sustained while the receiver takes
// results; the slot update completes in the accepting cycle. When the
// receiver stalls, the result register holds and in_stall rises, so no
// further request is taken until the result leaves. Reset (rst, synchronous)
// empties all slots, sets keep_count to 8 and drops out_valid. The user
// must write keep_count (cfg_write/cfg_data) only while idle; not enforced.
`default_nettype none
module top_k_score_keeper #(
  parameter int unsigned MAX_KEEP = tks_pkg::MAX_KEEP_DEF,
  parameter int unsigned ID_BITS  = tks_pkg::ID_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_write,
  input  wire  [7:0]  cfg_data,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  func,
  input  wire  [23:0] cand_id,
  input  wire  [31:0] cand_score,
  input  wire  [6:0]  slot_index,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        inserted,
  output logic [6:0]  placed_rank,
  output logic        slot_full,
  output logic [23:0] slot_id,
  output logic [31:0] slot_score
);
  import tks_pkg::*;

  localparam int unsigned IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  logic [7:0]          keep_count;
  logic [7:0]          n_used;
  logic                take;
  func_t               fn;
  cell_ctl_t           ctl;
  logic [ID_BITS-1:0]  new_id;

  logic [MAX_KEEP-1:0] found, first, full_v, in_use;
  logic [ID_BITS-1:0]  ids    [MAX_KEEP];
  logic [31:0]         scores [MAX_KEEP];

  logic                ins_hit;
  logic [6:0]          rank;
  logic                rd_ok;
  logic [IDX_W-1:0]    rd_idx;

  assign in_stall = out_valid && out_stall;
  assign take     = in_valid && !in_stall;
  assign fn       = func_t'(func);
  assign n_used   = (keep_count > 8'(MAX_KEEP)) ? 8'(MAX_KEEP) : keep_count;
  assign new_id   = ID_BITS'(cand_id);

  always_comb begin
    ctl.ins   = take && (fn == FUNC_INSERT);
    ctl.clr   = take && (fn == FUNC_CLEAR);
    ctl.score = cand_score;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= 8'd8;
    end else if (cfg_write) begin
      keep_count <= cfg_data;
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_KEEP; g++) begin : g_cell
      assign in_use[g] = 8'(g) < n_used;
      if (g == 0) begin : g_head
        tks_cell #(.ID_BITS(ID_BITS)) u_cell (
          .clk(clk), .rst(rst), .ctl(ctl), .new_id(new_id), .in_use(in_use[g]),
          .prev_found(1'b0), .left_id('0), .left_score(EMPTY_SCORE),
          .left_full(1'b0), .found(found[g]), .first(first[g]),
          .id(ids[g]), .score(scores[g]), .full(full_v[g])
        );
      end else begin : g_body
        tks_cell #(.ID_BITS(ID_BITS)) u_cell (
          .clk(clk), .rst(rst), .ctl(ctl), .new_id(new_id), .in_use(in_use[g]),
          .prev_found(found[g-1]), .left_id(ids[g-1]), .left_score(scores[g-1]),
          .left_full(full_v[g-1]), .found(found[g]), .first(first[g]),
          .id(ids[g]), .score(scores[g]), .full(full_v[g])
        );
      end
    end
  endgenerate

  assign ins_hit = |found;

  always_comb begin
    rank = '0;
    for (int i = 0; i < MAX_KEEP; i++) begin
      if (first[i]) rank = rank | 7'(i);
    end
  end

  assign rd_idx = slot_index[IDX_W-1:0];
  assign rd_ok  = ({1'b0, slot_index} < n_used) && full_v[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      inserted    <= 1'b0;
      placed_rank <= '0;
      slot_full   <= 1'b0;
      slot_id     <= '0;
      slot_score  <= '0;
      case (fn)
        FUNC_INSERT: begin
          inserted    <= ins_hit;
          placed_rank <= ins_hit ? rank : 7'd0;
        end
        FUNC_READ: begin
          slot_full  <= rd_ok;
          slot_id    <= rd_ok ? 24'(ids[rd_idx]) : 24'd0;
          slot_score <= rd_ok ? scores[rd_idx] : EMPTY_SCORE;
        end
        default: begin
        end
      endcase
    end
  end

  a_one_first: assert property (@(posedge clk) disable iff (rst) $onehot0(first))
    else $error("more than one insertion point");
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");
  a_take_result: assert property (@(posedge clk) disable iff (rst) take |=> out_valid)
    else $error("request produced no result");
  a_rank_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && inserted) |-> ({1'b0, placed_rank} < 8'(MAX_KEEP)))
    else $error("rank beyond chain");

endmodule
`default_nettype wire
